// File: rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SMMA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("smma assertion failed");

// next-cycle implication
`define SMMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("smma assertion failed");

`endif

// File: rtl/core/smma_pkg.sv
// Shared types and constants of the scaled matrix multiply-accumulate core.
// No dependencies.
package smma_pkg;

  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int MAX_DIM_DEF = 16;

  localparam logic [2:0] MODE_WR_A = 3'd0;
  localparam logic [2:0] MODE_WR_B = 3'd1;
  localparam logic [2:0] MODE_WR_C = 3'd2;
  localparam logic [2:0] MODE_CALC = 3'd3;
  localparam logic [2:0] MODE_RD_C = 3'd4;

  localparam logic [2:0] CFG_TRANS_A = 3'd0;
  localparam logic [2:0] CFG_TRANS_B = 3'd1;
  localparam logic [2:0] CFG_ROWS    = 3'd2;
  localparam logic [2:0] CFG_COLS    = 3'd3;
  localparam logic [2:0] CFG_INNER   = 3'd4;
  localparam logic [2:0] CFG_ALPHA   = 3'd5;
  localparam logic [2:0] CFG_BETA    = 3'd6;

  typedef struct packed {
    logic [2:0]               mode;
    logic [3:0]               row;
    logic [3:0]               col;
    logic signed [DATA_W-1:0] value;
  } smma_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic                     status;
    logic                     saturated;
  } smma_rsp_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } smma_ctl_t;

endpackage

// File: rtl/core/smma_cell.sv
// One accumulator cell of the chain: passes operand tokens right, shifts sums left.
// Depends on smma_pkg.
module smma_cell import smma_pkg::*; #(
  parameter int MAX_DIM  = MAX_DIM_DEF,
  parameter int CELL_IDX = 0,
  localparam int IDXW = $clog2(MAX_DIM),
  localparam int AW   = 2 * DATA_W + $clog2(MAX_DIM) + 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  smma_ctl_t                ctl_i,
  input  logic                     tok_vld_i,
  input  logic [IDXW-1:0]          tok_tag_i,
  input  logic signed [DATA_W-1:0] tok_a_i,
  input  logic signed [DATA_W-1:0] tok_b_i,
  output logic                     tok_vld_o,
  output logic [IDXW-1:0]          tok_tag_o,
  output logic signed [DATA_W-1:0] tok_a_o,
  output logic signed [DATA_W-1:0] tok_b_o,
  input  logic signed [AW-1:0]     acc_next_i,
  output logic signed [AW-1:0]     acc_o
);

  logic                       vld_q, pv_q;
  logic [IDXW-1:0]            tag_q;
  logic signed [DATA_W-1:0]   a_q, b_q;
  logic signed [2*DATA_W-1:0] prod_q;
  logic signed [AW-1:0]       acc_q;
  logic                       hit;

  assign hit = tok_vld_i && (tok_tag_i == IDXW'(CELL_IDX));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      pv_q  <= 1'b0;
    end else begin
      vld_q <= tok_vld_i;
      pv_q  <= hit;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tok_tag_i;
    a_q    <= tok_a_i;
    b_q    <= tok_b_i;
    prod_q <= tok_a_i * tok_b_i;
    if (ctl_i.clr) begin
      acc_q <= '0;
    end else if (ctl_i.shift) begin
      acc_q <= acc_next_i;
    end else if (pv_q) begin
      acc_q <= acc_q + AW'(prod_q);
    end
  end

  assign tok_vld_o = vld_q;
  assign tok_tag_o = tag_q;
  assign tok_a_o   = a_q;
  assign tok_b_o   = b_q;
  assign acc_o     = acc_q;

endmodule

// File: rtl/core/smma_chain.sv
// Row of accumulator cells holding one row of the product.
// Depends on smma_pkg and smma_cell.
module smma_chain import smma_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF,
  localparam int IDXW = $clog2(MAX_DIM),
  localparam int AW   = 2 * DATA_W + $clog2(MAX_DIM) + 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  smma_ctl_t                ctl_i,
  input  logic                     tok_vld_i,
  input  logic [IDXW-1:0]          tok_tag_i,
  input  logic signed [DATA_W-1:0] tok_a_i,
  input  logic signed [DATA_W-1:0] tok_b_i,
  output logic signed [AW-1:0]     acc_o
);

  logic                     vld [0:MAX_DIM];
  logic [IDXW-1:0]          tag [0:MAX_DIM];
  logic signed [DATA_W-1:0] opa [0:MAX_DIM];
  logic signed [DATA_W-1:0] opb [0:MAX_DIM];
  logic signed [AW-1:0]     acc [0:MAX_DIM];

  assign vld[0]       = tok_vld_i;
  assign tag[0]       = tok_tag_i;
  assign opa[0]       = tok_a_i;
  assign opb[0]       = tok_b_i;
  assign acc[MAX_DIM] = '0;

  for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
    smma_cell #(.MAX_DIM(MAX_DIM), .CELL_IDX(c)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl_i),
      .tok_vld_i  (vld[c]),
      .tok_tag_i  (tag[c]),
      .tok_a_i    (opa[c]),
      .tok_b_i    (opb[c]),
      .tok_vld_o  (vld[c+1]),
      .tok_tag_o  (tag[c+1]),
      .tok_a_o    (opa[c+1]),
      .tok_b_o    (opb[c+1]),
      .acc_next_i (acc[c+1]),
      .acc_o      (acc[c])
    );
  end

  assign acc_o = acc[0];

endmodule

// File: rtl/core/scaled_matrix_multiply_accumulate.sv
// Scaled matrix multiply-accumulate C = alpha*op(A)*op(B) + beta*C, Q16.16.
// Writes and rejected requests answer in the cycle after acceptance, reads of C via the S_RD state.
// Compute runs row by row: K*N operand reads feed the cell chain one per cycle, then,
// after a drain, a shared post unit steps through S_P0 to S_P5 for each element.
// Reset sets the configuration registers to their defaults and clears the saturation flag;
// the A, B and C stores keep no reset. Depends on smma_pkg, smma_chain and assert_macros.svh.
module scaled_matrix_multiply_accumulate import smma_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  smma_req_t         in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output smma_rsp_t         out_rsp_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [DATA_W-1:0] cfg_data_i
);

  localparam int IDXW  = $clog2(MAX_DIM);
  localparam int ADW   = 2 * IDXW;
  localparam int DIMW  = $clog2(MAX_DIM + 1);
  localparam int DCW   = $clog2(MAX_DIM + 4);
  localparam int AW    = 2 * DATA_W + $clog2(MAX_DIM) + 1;
  localparam int EW    = (AW > 2 * DATA_W) ? AW : 2 * DATA_W + 1;
  localparam int TW    = 3 * DATA_W + 2;
  localparam logic signed [AW-1:0] HALF_A = AW'(1) <<< (FRAC_W - 1);
  localparam logic signed [TW-1:0] HALF_T = TW'(1) <<< (FRAC_W - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_ROW   = 4'd2;
  localparam logic [3:0] S_FEED  = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_P0    = 4'd5;
  localparam logic [3:0] S_P1    = 4'd6;
  localparam logic [3:0] S_P2    = 4'd7;
  localparam logic [3:0] S_P3    = 4'd8;
  localparam logic [3:0] S_P4    = 4'd9;
  localparam logic [3:0] S_P5    = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  function automatic logic [DIMW-1:0] clamp_dim(input logic [4:0] r);
    return (int'(r) > MAX_DIM) ? DIMW'(MAX_DIM) : DIMW'(r);
  endfunction

  logic                     ta_q, tb_q;
  logic [4:0]               rows_q, cols_q, inner_q;
  logic signed [DATA_W-1:0] alpha_q, beta_q;
  logic [3:0]               state_q;
  logic                     out_valid_q, sat_q;
  smma_rsp_t                out_q;
  logic [DIMW-1:0]          i_q, j_q, k_q;
  logic [DCW-1:0]           drain_q;

  logic signed [DATA_W-1:0] mem_a [0:2**ADW-1];
  logic signed [DATA_W-1:0] mem_b [0:2**ADW-1];
  logic signed [DATA_W-1:0] mem_c [0:2**ADW-1];
  logic signed [DATA_W-1:0] a_rd_q, b_rd_q, c_rd_q;
  logic                     tok_vld_q;
  logic [IDXW-1:0]          tok_tag_q;

  logic signed [2*DATA_W-1:0] dot_q;
  logic signed [2*DATA_W:0]   p_lo_q;
  logic signed [2*DATA_W-1:0] p_hi_q, p_c_q;
  logic signed [TW-1:0]       t_q;

  logic [DIMW-1:0]   dm, dn, dk, rlim, clim;
  logic              accept, shape_ok;
  logic [IDXW-1:0]   row_ix, col_ix, i_ix, j_ix, k_ix;
  logic [ADW-1:0]    req_addr, a_addr, b_addr, c_raddr, c_paddr;
  smma_ctl_t         ctl;
  logic signed [AW-1:0]       acc0, racc;
  logic signed [EW-1:0]       racc_x;
  logic [EW-2*DATA_W:0]       racc_hi;
  logic signed [2*DATA_W-1:0] dot_d;
  logic                       dot_sat;
  logic signed [TW-1:0]       rt;
  logic [TW-DATA_W:0]         rt_hi;
  logic signed [DATA_W-1:0]   res_d;
  logic                       res_sat;

  assign dm = clamp_dim(rows_q);
  assign dn = clamp_dim(cols_q);
  assign dk = clamp_dim(inner_q);

  always_comb begin
    rlim = '0;
    clim = '0;
    case (in_req_i.mode)
      MODE_WR_A: begin
        rlim = ta_q ? dk : dm;
        clim = ta_q ? dm : dk;
      end
      MODE_WR_B: begin
        rlim = tb_q ? dn : dk;
        clim = tb_q ? dk : dn;
      end
      MODE_WR_C, MODE_RD_C: begin
        rlim = dm;
        clim = dn;
      end
      default: begin
        rlim = '0;
        clim = '0;
      end
    endcase
  end

  assign shape_ok = (int'(in_req_i.row) < int'(rlim)) && (int'(in_req_i.col) < int'(clim));
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  assign row_ix   = IDXW'(in_req_i.row);
  assign col_ix   = IDXW'(in_req_i.col);
  assign i_ix     = i_q[IDXW-1:0];
  assign j_ix     = j_q[IDXW-1:0];
  assign k_ix     = k_q[IDXW-1:0];
  assign req_addr = {row_ix, col_ix};
  assign a_addr   = ta_q ? {k_ix, i_ix} : {i_ix, k_ix};
  assign b_addr   = tb_q ? {j_ix, k_ix} : {k_ix, j_ix};
  assign c_paddr  = {i_ix, j_ix};
  assign c_raddr  = (state_q == S_P0) ? c_paddr : req_addr;

  always_ff @(posedge clk_i) begin
    if (accept && shape_ok && in_req_i.mode == MODE_WR_A) begin
      mem_a[req_addr] <= in_req_i.value;
    end
    if (state_q == S_FEED) begin
      a_rd_q <= mem_a[a_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && shape_ok && in_req_i.mode == MODE_WR_B) begin
      mem_b[req_addr] <= in_req_i.value;
    end
    if (state_q == S_FEED) begin
      b_rd_q <= mem_b[b_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && shape_ok && in_req_i.mode == MODE_WR_C) begin
      mem_c[req_addr] <= in_req_i.value;
    end else if (state_q == S_P5) begin
      mem_c[c_paddr] <= res_d;
    end
    if (state_q == S_IDLE || state_q == S_P0) begin
      c_rd_q <= mem_c[c_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= (state_q == S_FEED);
    end
  end

  always_ff @(posedge clk_i) begin
    tok_tag_q <= j_ix;
  end

  assign ctl.clr   = (state_q == S_ROW);
  assign ctl.shift = (state_q == S_P0);

  smma_chain #(.MAX_DIM(MAX_DIM)) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .tok_vld_i (tok_vld_q),
    .tok_tag_i (tok_tag_q),
    .tok_a_i   (a_rd_q),
    .tok_b_i   (b_rd_q),
    .acc_o     (acc0)
  );

  always_comb begin
    racc    = (acc0 + HALF_A) >>> FRAC_W;
    racc_x  = EW'(racc);
    racc_hi = racc_x[EW-1:2*DATA_W-1];
    dot_sat = !((&racc_hi) || !(|racc_hi));
    if (!dot_sat) begin
      dot_d = racc_x[2*DATA_W-1:0];
    end else if (racc_x[EW-1]) begin
      dot_d = {1'b1, {(2*DATA_W-1){1'b0}}};
    end else begin
      dot_d = {1'b0, {(2*DATA_W-1){1'b1}}};
    end
    rt      = (t_q + HALF_T) >>> FRAC_W;
    rt_hi   = rt[TW-1:DATA_W-1];
    res_sat = !((&rt_hi) || !(|rt_hi));
    if (!res_sat) begin
      res_d = rt[DATA_W-1:0];
    end else if (rt[TW-1]) begin
      res_d = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      res_d = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_P0: dot_q <= dot_d;
      S_P1: p_lo_q <= alpha_q * $signed({1'b0, dot_q[DATA_W-1:0]});
      S_P2: p_hi_q <= alpha_q * $signed(dot_q[2*DATA_W-1:DATA_W]);
      S_P3: p_c_q <= beta_q * c_rd_q;
      S_P4: t_q <= (TW'(p_hi_q) <<< DATA_W) + TW'(p_lo_q)
                   + ((beta_q != '0) ? TW'(p_c_q) : TW'(0));
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ta_q    <= 1'b0;
      tb_q    <= 1'b0;
      rows_q  <= 5'd16;
      cols_q  <= 5'd16;
      inner_q <= 5'd16;
      alpha_q <= 32'sd65536;
      beta_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TRANS_A: ta_q    <= cfg_data_i[0];
        CFG_TRANS_B: tb_q    <= cfg_data_i[0];
        CFG_ROWS:    rows_q  <= cfg_data_i[4:0];
        CFG_COLS:    cols_q  <= cfg_data_i[4:0];
        CFG_INNER:   inner_q <= cfg_data_i[4:0];
        CFG_ALPHA:   alpha_q <= cfg_data_i;
        CFG_BETA:    beta_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      sat_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      drain_q     <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_req_i.mode == MODE_CALC) begin
              sat_q <= 1'b0;
              i_q   <= '0;
              state_q <= (dm == '0 || dn == '0) ? S_DONE : S_ROW;
            end else if (in_req_i.mode == MODE_RD_C && shape_ok) begin
              state_q <= S_RD;
            end else begin
              out_valid_q        <= 1'b1;
              out_q.read_value   <= '0;
              out_q.status       <= !shape_ok;
              out_q.saturated    <= sat_q;
            end
          end
        end
        S_RD: begin
          out_valid_q      <= 1'b1;
          out_q.read_value <= c_rd_q;
          out_q.status     <= 1'b0;
          out_q.saturated  <= sat_q;
          state_q          <= S_IDLE;
        end
        S_ROW: begin
          j_q     <= '0;
          k_q     <= '0;
          drain_q <= '0;
          state_q <= (dk == '0) ? S_DRAIN : S_FEED;
        end
        S_FEED: begin
          if (j_q == dn - 1'b1) begin
            j_q <= '0;
            if (k_q == dk - 1'b1) begin
              drain_q <= '0;
              state_q <= S_DRAIN;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_DRAIN: begin
          if (drain_q == DCW'(MAX_DIM + 3)) begin
            j_q     <= '0;
            state_q <= S_P0;
          end else begin
            drain_q <= drain_q + 1'b1;
          end
        end
        S_P0: begin
          if (dot_sat) begin
            sat_q <= 1'b1;
          end
          state_q <= S_P1;
        end
        S_P1: state_q <= S_P2;
        S_P2: state_q <= S_P3;
        S_P3: state_q <= S_P4;
        S_P4: state_q <= S_P5;
        S_P5: begin
          if (res_sat) begin
            sat_q <= 1'b1;
          end
          if (j_q == dn - 1'b1) begin
            if (i_q == dm - 1'b1) begin
              state_q <= S_DONE;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_ROW;
            end
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_P0;
          end
        end
        S_DONE: begin
          out_valid_q      <= 1'b1;
          out_q.read_value <= '0;
          out_q.status     <= 1'b0;
          out_q.saturated  <= sat_q;
          state_q          <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`include "assert_macros.svh"

  `SMMA_ASSERT_IMP(a_feed_no_rsp, state_q == S_FEED, !out_valid_q)
  `SMMA_ASSERT_NEXT(a_read_one_cycle, state_q == S_RD, out_valid_q && state_q == S_IDLE)
  `SMMA_ASSERT_IMP(a_tok_from_feed, tok_vld_q, $past(state_q) == S_FEED)

endmodule
